// File: design/gbs_pkg.sv
package gbs_pkg;

	// Field widths
	localparam int FRAC_BITS = 32;
	localparam int PIX_W     = 8;
	localparam int IDX_W     = 17;
	localparam int MEAN_W    = PIX_W + FRAC_BITS;
	localparam int VAR_W     = 2 * PIX_W + FRAC_BITS;
	localparam int ALPHA_W   = 32;
	localparam int K_W       = 8;
	localparam int KK_W      = 2 * K_W;

	// Datapath split at the alpha width (Q0.32 rounding point)
	localparam int LO_W   = ALPHA_W;
	localparam int MH_W   = MEAN_W - LO_W;
	localparam int VH_W   = VAR_W - LO_W;
	localparam int PROD_W = 2 * LO_W;
	localparam int D2_W   = 2 * MEAN_W;
	localparam int KV_W   = KK_W + VAR_W;
	localparam int CMP_W  = KV_W + FRAC_BITS;

	// Pixel beat functions
	localparam logic FUNC_INIT   = 1'b0;
	localparam logic FUNC_UPDATE = 1'b1;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;

	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 32'd4295;
	localparam logic [K_W-1:0]     K_RESET     = 8'd30;
	localparam logic [KK_W-1:0]    KK_RESET    = KK_W'(K_RESET) * KK_W'(K_RESET);

	localparam int NUM_PIXELS_DEFAULT = 131072;

	// Cycles from an accepted pixel beat to its mask beat
	localparam int LATENCY = 15;

endpackage

// File: design/gaussian_background_subtractor.sv
// Pipeline: sixteen register stages (address, store read, mean blend, d squared, variance blend,
// k*k*var, compare) between an accepted pixel beat and its mask beat.
// Throughput: one beat per cycle unless the mask channel stalls; a beat whose store address
// matches an older beat not yet written back (stages 3 to 13) waits at the address stage until
// that write lands. Reset: clears all stage valid bits, loads alpha 4295 and threshold 30; the
// mean and variance stores have no reset and are undefined until an init beat writes them.
module gaussian_background_subtractor #(
	parameter int NUM_PIXELS = gbs_pkg::NUM_PIXELS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// pixel channel
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic                              func,
	input  logic [gbs_pkg::IDX_W-1:0]         pixel_index,
	input  logic [gbs_pkg::PIX_W-1:0]         pixel_value,
	input  logic [gbs_pkg::MEAN_W-1:0]        init_mean,
	input  logic [gbs_pkg::VAR_W-1:0]         init_variance,
	// mask channel
	output logic                              mask_valid,
	input  logic                              mask_stall,
	output logic [gbs_pkg::IDX_W-1:0]         out_index,
	output logic                              foreground,
	// configuration channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gbs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gbs_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int IDX_W      = gbs_pkg::IDX_W;
	localparam int MEAN_W     = gbs_pkg::MEAN_W;
	localparam int VAR_W      = gbs_pkg::VAR_W;
	localparam int LO_W       = gbs_pkg::LO_W;
	localparam int PROD_W     = gbs_pkg::PROD_W;
	localparam int ADDR_W     = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
	localparam int NUM_STAGES = 16;
	localparam int RD_STAGE   = 2;
	localparam int WR_STAGE   = 13;

	// Exact reciprocal for index modulo NUM_PIXELS over all 17-bit indexes
	localparam int REC_SHIFT = IDX_W + $clog2(NUM_PIXELS);
	localparam int REC_W     = IDX_W + 2;
	localparam logic [63:0] REC_MUL64 =
		((64'd1 << REC_SHIFT) + 64'(NUM_PIXELS) - 64'd1) / 64'(NUM_PIXELS);
	localparam logic [REC_W-1:0] REC_MUL  = REC_MUL64[REC_W-1:0];
	localparam logic [IDX_W-1:0] NUM_LOW  = IDX_W'(NUM_PIXELS);

	typedef struct packed {
		logic              func;
		logic [IDX_W-1:0]  index;
		logic [ADDR_W-1:0] addr;
	} tag_t;

	// Control
	logic [NUM_STAGES:1] vld_q;
	logic [NUM_STAGES:1] adv;
	logic [NUM_STAGES:1] room;
	logic                hazard;
	logic                accept;
	tag_t                tag_q [1:NUM_STAGES];

	// Configuration
	logic [gbs_pkg::ALPHA_W-1:0] alpha_q;
	logic [gbs_pkg::KK_W-1:0]    kk_q;

	// Stores
	logic [MEAN_W-1:0] mean_mem [NUM_PIXELS];
	logic [VAR_W-1:0]  var_mem  [NUM_PIXELS];

	// Stage payload
	logic [IDX_W+REC_W-1:0]  rec_prod;
	logic [IDX_W-1:0]        rem;
	logic [IDX_W-1:0]        quot_s1;
	logic [gbs_pkg::PIX_W-1:0] pix_s1, pix_s2, pix_s3;
	logic [MEAN_W-1:0]       imean_s1, imean_s2, imean_s3;
	logic [VAR_W-1:0]        ivar_s1, ivar_s2, ivar_s3;
	logic [MEAN_W-1:0]       mean_rd_s3;
	logic [VAR_W-1:0]        var_rd_s3;

	logic [MEAN_W-1:0]       mean_old_s4, mean_old_s5, mean_old_s6;
	logic [VAR_W-1:0]        var_old_s4, var_old_s5, var_old_s6, var_old_s7, var_old_s8;
	logic [VAR_W-1:0]        var_old_s9, var_old_s10, var_old_s11, var_old_s12;
	logic [MEAN_W-1:0]       diff_s4, diff_s5, diff_s6;
	logic                    ge_s4, ge_s5, ge_s6;
	logic [MEAN_W-1:0]       mp_hi_s5;
	logic [PROD_W-1:0]       mp_lo_s5;
	logic [MEAN_W-1:0]       mscale_s6;

	logic [MEAN_W-1:0]       mean_new_s7, mean_new_s8, mean_new_s9, mean_new_s10;
	logic [MEAN_W-1:0]       mean_new_s11, mean_new_s12, mean_new_s13;
	logic [MEAN_W-1:0]       d_s7;
	logic [PROD_W-1:0]       dp_ll_s8;
	logic [MEAN_W-1:0]       dp_hl_s8;
	logic [2*gbs_pkg::MH_W-1:0] dp_hh_s8;
	logic [gbs_pkg::D2_W-1:0] d2_s9, d2_s10, d2_s11, d2_s12, d2_s13, d2_s14, d2_s15;

	logic [VAR_W-1:0]        dsq;
	logic [VAR_W-1:0]        vdiff_s10;
	logic                    vge_s10, vge_s11, vge_s12;
	logic [VAR_W-1:0]        vp_hi_s11;
	logic [PROD_W-1:0]       vp_lo_s11;
	logic [VAR_W-1:0]        vscale_s12;
	logic [VAR_W-1:0]        var_new_s13;

	logic [gbs_pkg::KK_W+LO_W-1:0] kp_lo_s14;
	logic [gbs_pkg::KK_W+gbs_pkg::VH_W-1:0] kp_hi_s14;
	logic [gbs_pkg::KV_W-1:0] kv_s15;
	logic                    fg_s16;

	logic [MEAN_W-1:0]       pixq;
	logic [MEAN_W-1:0]       mean_pick;
	logic [VAR_W-1:0]        var_pick;

	// Configuration registers; k is kept squared
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= gbs_pkg::ALPHA_RESET;
			kk_q    <= gbs_pkg::KK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gbs_pkg::CFG_ALPHA: begin
					alpha_q <= cfg_data[gbs_pkg::ALPHA_W-1:0];
				end
				gbs_pkg::CFG_THRESHOLD: begin
					kk_q <= gbs_pkg::KK_W'(cfg_data[gbs_pkg::K_W-1:0])
						* gbs_pkg::KK_W'(cfg_data[gbs_pkg::K_W-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	// Hold the address stage while an older beat to the same address has not written back
	always_comb begin
		hazard = 1'b0;
		for (int k = RD_STAGE + 1; k <= WR_STAGE; k++) begin
			if (vld_q[k] && (tag_q[k].addr == tag_q[RD_STAGE].addr)) begin
				hazard = 1'b1;
			end
		end
	end

	// Advance each stage when the next one has room; bubbles collapse
	always_comb begin
		adv[NUM_STAGES]  = vld_q[NUM_STAGES] && !mask_stall;
		room[NUM_STAGES] = !vld_q[NUM_STAGES] || !mask_stall;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			adv[k]  = vld_q[k] && room[k+1] && !((k == RD_STAGE) && hazard);
			room[k] = !vld_q[k] || adv[k];
		end
	end

	assign item_stall = !room[1];
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q[1] <= accept || (vld_q[1] && !adv[1]);
			for (int k = 2; k <= NUM_STAGES; k++) begin
				vld_q[k] <= adv[k-1] || (vld_q[k] && !adv[k]);
			end
		end
	end

	// Index reduction: quotient by reciprocal, then remainder
	assign rec_prod = (IDX_W+REC_W)'(pixel_index) * (IDX_W+REC_W)'(REC_MUL);
	assign rem      = tag_q[1].index - quot_s1 * NUM_LOW;

	// Tags travel with their beats
	always_ff @(posedge clk) begin
		if (accept) begin
			tag_q[1] <= '{func: func, index: pixel_index, addr: '0};
		end
		if (adv[1]) begin
			tag_q[2] <= '{func: tag_q[1].func, index: tag_q[1].index, addr: ADDR_W'(rem)};
		end
		for (int k = 3; k <= NUM_STAGES; k++) begin
			if (adv[k-1]) begin
				tag_q[k] <= tag_q[k-1];
			end
		end
	end

	// Store read at the address stage, write back when the variance is final
	always_ff @(posedge clk) begin
		if (adv[WR_STAGE]) begin
			mean_mem[tag_q[WR_STAGE].addr] <= mean_new_s13;
			var_mem[tag_q[WR_STAGE].addr]  <= var_new_s13;
		end
		if (adv[RD_STAGE]) begin
			mean_rd_s3 <= mean_mem[tag_q[RD_STAGE].addr];
			var_rd_s3  <= var_mem[tag_q[RD_STAGE].addr];
		end
	end

	assign pixq = {pix_s3, {gbs_pkg::FRAC_BITS{1'b0}}};
	assign dsq  = d2_s9[gbs_pkg::FRAC_BITS +: VAR_W];

	// Old model: stored on updates, carried in the beat on inits
	assign mean_pick = (tag_q[3].func == gbs_pkg::FUNC_UPDATE) ? mean_rd_s3 : imean_s3;
	assign var_pick  = (tag_q[3].func == gbs_pkg::FUNC_UPDATE) ? var_rd_s3 : ivar_s3;

	always_ff @(posedge clk) begin
		// s1: capture the beat, start the address quotient
		if (accept) begin
			pix_s1   <= pixel_value;
			imean_s1 <= init_mean;
			ivar_s1  <= init_variance;
			quot_s1  <= IDX_W'(rec_prod >> REC_SHIFT);
		end
		// s2: address ready
		if (adv[1]) begin
			pix_s2   <= pix_s1;
			imean_s2 <= imean_s1;
			ivar_s2  <= ivar_s1;
		end
		// s3: store data arrives
		if (adv[2]) begin
			pix_s3   <= pix_s2;
			imean_s3 <= imean_s2;
			ivar_s3  <= ivar_s2;
		end
		// s4: pick old model, distance from pixel to old mean
		if (adv[3]) begin
			mean_old_s4 <= mean_pick;
			var_old_s4  <= var_pick;
			ge_s4       <= pixq >= mean_pick;
			diff_s4     <= (pixq >= mean_pick) ? pixq - mean_pick : mean_pick - pixq;
		end
		// s5: scale the distance by alpha in two partial products
		if (adv[4]) begin
			mean_old_s5 <= mean_old_s4;
			var_old_s5  <= var_old_s4;
			diff_s5     <= diff_s4;
			ge_s5       <= ge_s4;
			mp_hi_s5    <= MEAN_W'(diff_s4[MEAN_W-1:LO_W]) * MEAN_W'(alpha_q);
			mp_lo_s5    <= PROD_W'(diff_s4[LO_W-1:0]) * PROD_W'(alpha_q);
		end
		// s6: rounded step size
		if (adv[5]) begin
			mean_old_s6 <= mean_old_s5;
			var_old_s6  <= var_old_s5;
			diff_s6     <= diff_s5;
			ge_s6       <= ge_s5;
			mscale_s6   <= mp_hi_s5 + MEAN_W'(mp_lo_s5[PROD_W-1:LO_W])
				+ MEAN_W'(mp_lo_s5[LO_W-1]);
		end
		// s7: new mean; the new mean lies between old and pixel, so d shrinks by the step
		if (adv[6]) begin
			mean_new_s7 <= (tag_q[6].func == gbs_pkg::FUNC_INIT) ? mean_old_s6
				: (ge_s6 ? mean_old_s6 + mscale_s6 : mean_old_s6 - mscale_s6);
			var_old_s7  <= var_old_s6;
			d_s7        <= diff_s6 - mscale_s6;
		end
		// s8: d squared partial products
		if (adv[7]) begin
			mean_new_s8 <= mean_new_s7;
			var_old_s8  <= var_old_s7;
			dp_ll_s8    <= PROD_W'(d_s7[LO_W-1:0]) * PROD_W'(d_s7[LO_W-1:0]);
			dp_hl_s8    <= MEAN_W'(d_s7[MEAN_W-1:LO_W]) * MEAN_W'(d_s7[LO_W-1:0]);
			dp_hh_s8    <= (2*gbs_pkg::MH_W)'(d_s7[MEAN_W-1:LO_W])
				* (2*gbs_pkg::MH_W)'(d_s7[MEAN_W-1:LO_W]);
		end
		// s9: full d squared
		if (adv[8]) begin
			mean_new_s9 <= mean_new_s8;
			var_old_s9  <= var_old_s8;
			d2_s9       <= {dp_hh_s8, dp_ll_s8}
				+ (gbs_pkg::D2_W'(dp_hl_s8) << (LO_W + 1));
		end
		// s10: distance from old variance to d squared
		if (adv[9]) begin
			mean_new_s10 <= mean_new_s9;
			var_old_s10  <= var_old_s9;
			d2_s10       <= d2_s9;
			vge_s10      <= dsq >= var_old_s9;
			vdiff_s10    <= (dsq >= var_old_s9) ? dsq - var_old_s9 : var_old_s9 - dsq;
		end
		// s11: scale by alpha
		if (adv[10]) begin
			mean_new_s11 <= mean_new_s10;
			var_old_s11  <= var_old_s10;
			d2_s11       <= d2_s10;
			vge_s11      <= vge_s10;
			vp_hi_s11    <= VAR_W'(vdiff_s10[VAR_W-1:LO_W]) * VAR_W'(alpha_q);
			vp_lo_s11    <= PROD_W'(vdiff_s10[LO_W-1:0]) * PROD_W'(alpha_q);
		end
		// s12: rounded variance step
		if (adv[11]) begin
			mean_new_s12 <= mean_new_s11;
			var_old_s12  <= var_old_s11;
			d2_s12       <= d2_s11;
			vge_s12      <= vge_s11;
			vscale_s12   <= vp_hi_s11 + VAR_W'(vp_lo_s11[PROD_W-1:LO_W])
				+ VAR_W'(vp_lo_s11[LO_W-1]);
		end
		// s13: new variance, ready for write back
		if (adv[12]) begin
			mean_new_s13 <= mean_new_s12;
			var_new_s13  <= (tag_q[12].func == gbs_pkg::FUNC_INIT) ? var_old_s12
				: (vge_s12 ? var_old_s12 + vscale_s12 : var_old_s12 - vscale_s12);
			d2_s13       <= d2_s12;
		end
		// s14: k*k*var partial products
		if (adv[13]) begin
			d2_s14    <= d2_s13;
			kp_lo_s14 <= (gbs_pkg::KK_W+LO_W)'(kk_q)
				* (gbs_pkg::KK_W+LO_W)'(var_new_s13[LO_W-1:0]);
			kp_hi_s14 <= (gbs_pkg::KK_W+gbs_pkg::VH_W)'(kk_q)
				* (gbs_pkg::KK_W+gbs_pkg::VH_W)'(var_new_s13[VAR_W-1:LO_W]);
		end
		// s15: k*k*var
		if (adv[14]) begin
			d2_s15 <= d2_s14;
			kv_s15 <= gbs_pkg::KV_W'(kp_lo_s14) + {kp_hi_s14, {LO_W{1'b0}}};
		end
		// s16: foreground when d*d exceeds k*k*var at the same scale; init beats give zero
		if (adv[15]) begin
			fg_s16 <= (tag_q[15].func == gbs_pkg::FUNC_UPDATE) && (gbs_pkg::CMP_W'(d2_s15)
				> {kv_s15, {gbs_pkg::FRAC_BITS{1'b0}}});
		end
	end

	assign mask_valid = vld_q[NUM_STAGES];
	assign out_index  = tag_q[NUM_STAGES].index;
	assign foreground = fg_s16;

endmodule

// File: design/gbs_checker.sv
module gbs_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      item_stall,
	input logic                      mask_valid,
	input logic                      mask_stall,
	input logic [gbs_pkg::IDX_W-1:0] out_index,
	input logic                      foreground
);

	// A stalled mask beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		mask_valid && mask_stall |=> mask_valid && $stable(out_index) && $stable(foreground))
		else $error("mask beat changed while stalled");

	// Reset empties the pipeline by the next edge
	assert property (@(posedge clk) !arst_n |=> !mask_valid)
		else $error("mask valid during reset");

	// An empty pipeline takes a beat right after reset
	assert property (@(posedge clk) $rose(arst_n) |-> !item_stall)
		else $error("pixel channel stalled right after reset");

	// No mask beat can appear sooner than the pipeline latency after reset
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mask_valid) |-> $past(arst_n, gbs_pkg::LATENCY))
		else $error("mask beat earlier than pipeline latency");

endmodule

bind gaussian_background_subtractor gbs_checker u_gbs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_stall (item_stall),
	.mask_valid (mask_valid),
	.mask_stall (mask_stall),
	.out_index  (out_index),
	.foreground (foreground)
);

// File: tb/gaussian_background_subtractor_test.sv
`timescale 1ns / 100ps

module gaussian_background_subtractor_test;

	localparam int IDX_W      = gbs_pkg::IDX_W;
	localparam int PIX_W      = gbs_pkg::PIX_W;
	localparam int MEAN_W     = gbs_pkg::MEAN_W;
	localparam int VAR_W      = gbs_pkg::VAR_W;
	localparam int ALPHA_W    = gbs_pkg::ALPHA_W;
	localparam int K_W        = gbs_pkg::K_W;
	localparam int FRAC_BITS  = gbs_pkg::FRAC_BITS;
	localparam int CFG_IDX_W  = gbs_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = gbs_pkg::CFG_DATA_W;
	localparam int LATENCY    = gbs_pkg::LATENCY;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = gbs_pkg::CFG_ALPHA;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = gbs_pkg::CFG_THRESHOLD;
	localparam logic [ALPHA_W-1:0]   ALPHA_RESET   = gbs_pkg::ALPHA_RESET;
	localparam logic [K_W-1:0]       K_RESET       = gbs_pkg::K_RESET;

	typedef logic [127:0] wide_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             fg;
	} mask_t;

	localparam logic FUNC_INIT   = gbs_pkg::FUNC_INIT;
	localparam logic FUNC_UPDATE = gbs_pkg::FUNC_UPDATE;
	localparam logic [ALPHA_W-1:0] ALPHA_MAX = '1;
	localparam logic [K_W-1:0]     K_MAX     = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  item_valid = 1'b0;
	logic                  item_stall;
	logic                  func = FUNC_INIT;
	logic [IDX_W-1:0]      pixel_index = '0;
	logic [PIX_W-1:0]      pixel_value = '0;
	logic [MEAN_W-1:0]     init_mean = '0;
	logic [VAR_W-1:0]      init_variance = '0;

	logic                  mask_valid;
	logic                  mask_stall = 1'b0;
	logic [IDX_W-1:0]      out_index;
	logic                  foreground;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_ALPHA;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow of the pixel model and the configuration
	logic [MEAN_W-1:0]  bg_mean [int unsigned];
	logic [VAR_W-1:0]   bg_var [int unsigned];
	int unsigned        live_pixels [$];
	logic [ALPHA_W-1:0] cur_alpha = ALPHA_RESET;
	logic [K_W-1:0]     cur_k = K_RESET;

	mask_t mask_due [$];

	bit no_idle = 1'b0;
	int err_count = 0;
	int init_count = 0;
	int update_count = 0;
	int mask_count = 0;
	int fg_count = 0;
	int setting_count = 1;
	int stall_left = 0;

	gaussian_background_subtractor dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.func         (func),
		.pixel_index  (pixel_index),
		.pixel_value  (pixel_value),
		.init_mean    (init_mean),
		.init_variance(init_variance),
		.mask_valid   (mask_valid),
		.mask_stall   (mask_stall),
		.out_index    (out_index),
		.foreground   (foreground),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Move old toward tgt by round(|tgt - old| * r / 2^32)
	function automatic wide_t blend_q32(wide_t old, wide_t tgt, logic [ALPHA_W-1:0] r);
		wide_t step;
		if (tgt >= old) begin
			step = ((tgt - old) * r + (wide_t'(1) << 31)) >> 32;
			return old + step;
		end
		step = ((old - tgt) * r + (wide_t'(1) << 31)) >> 32;
		return old - step;
	endfunction

	// Apply one pixel beat to the shadow model and return its mask bit
	function automatic logic predict_mask(logic f, logic [IDX_W-1:0] idx,
			logic [PIX_W-1:0] pix, logic [MEAN_W-1:0] m0, logic [VAR_W-1:0] v0);
		int unsigned slot;
		wide_t pixq, mean_n, dev, dsq, var_n, kv;
		slot = 32'(idx);
		if (f == FUNC_INIT) begin
			bg_mean[slot] = m0;
			bg_var[slot] = v0;
			return 1'b0;
		end
		pixq = wide_t'(pix) << FRAC_BITS;
		mean_n = blend_q32(wide_t'(bg_mean[slot]), pixq, cur_alpha);
		dev = (pixq >= mean_n) ? pixq - mean_n : mean_n - pixq;
		dsq = ((dev * dev) >> FRAC_BITS) & ((wide_t'(1) << VAR_W) - 1);
		var_n = blend_q32(wide_t'(bg_var[slot]), dsq, cur_alpha);
		kv = wide_t'(cur_k) * wide_t'(cur_k) * var_n;
		bg_mean[slot] = mean_n[MEAN_W-1:0];
		bg_var[slot] = var_n[VAR_W-1:0];
		return (dev * dev) > (kv << FRAC_BITS);
	endfunction

	// Idle length: mostly none, some short, a few long
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [MEAN_W-1:0] rand_mean();
		return MEAN_W'({$urandom, $urandom});
	endfunction

	function automatic logic [VAR_W-1:0] rand_var();
		return VAR_W'({$urandom, $urandom});
	endfunction

	// Send one pixel beat; valid stays high after acceptance
	task automatic send_pixel(logic f, logic [IDX_W-1:0] idx, logic [PIX_W-1:0] pix,
			logic [MEAN_W-1:0] m0, logic [VAR_W-1:0] v0);
		int gap;
		mask_t want;
		gap = draw_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		func <= f;
		pixel_index <= idx;
		pixel_value <= pix;
		init_mean <= m0;
		init_variance <= v0;
		do @(posedge clk); while (item_stall);
		if (f == FUNC_INIT) begin
			init_count++;
			if (!bg_mean.exists(32'(idx)))
				live_pixels = {live_pixels, 32'(idx)};
		end else begin
			update_count++;
		end
		want.idx = idx;
		want.fg = predict_mask(f, idx, pix, m0, v0);
		mask_due = {mask_due, want};
	endtask

	task automatic init_pixel(logic [IDX_W-1:0] idx, logic [MEAN_W-1:0] m0,
			logic [VAR_W-1:0] v0);
		send_pixel(FUNC_INIT, idx, PIX_W'($urandom), m0, v0);
	endtask

	task automatic update_pixel(logic [IDX_W-1:0] idx, logic [PIX_W-1:0] pix);
		send_pixel(FUNC_UPDATE, idx, pix, rand_mean(), rand_var());
	endtask

	// Drop valid and wait until the pipeline is empty
	task automatic drain();
		item_valid <= 1'b0;
		while (mask_due.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// Write alpha then threshold, holding valid across both beats
	task automatic set_model(logic [ALPHA_W-1:0] a, logic [K_W-1:0] k);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_ALPHA;
		cfg_data <= CFG_DATA_W'(a);
		do @(posedge clk); while (!cfg_ready);
		cur_alpha = a;
		cfg_index <= CFG_THRESHOLD;
		cfg_data <= {(CFG_DATA_W-K_W)'($urandom), k};
		do @(posedge clk); while (!cfg_ready);
		cur_k = k;
		cfg_valid <= 1'b0;
		setting_count++;
	endtask

	// Field extremes, zero variance and back-to-back hits on one pixel
	task automatic test_directed_corners();
		drain();
		init_pixel(0, '1, '1);
		init_pixel('1, '0, '0);
		update_pixel(0, 8'd0);
		update_pixel(0, 8'hFF);
		update_pixel('1, 8'd0);
		update_pixel('1, 8'hFF);
		init_pixel(7, MEAN_W'(128) << FRAC_BITS, '0);
		update_pixel(7, 8'd128);
		update_pixel(7, 8'd129);
		update_pixel(7, 8'd129);
		update_pixel(7, 8'd0);
	endtask

	// Zero threshold: foreground exactly when the pixel is off the mean
	task automatic test_zero_threshold();
		drain();
		set_model(ALPHA_RESET, '0);
		init_pixel(9, MEAN_W'(60) << FRAC_BITS, VAR_W'(1) << 40);
		update_pixel(9, 8'd60);
		update_pixel(9, 8'd61);
	endtask

	// Frozen model, then a model that jumps to each new pixel
	task automatic test_alpha_extremes();
		drain();
		set_model('0, 8'd1);
		update_pixel(7, 8'd0);
		update_pixel(9, 8'd255);
		drain();
		set_model(ALPHA_MAX, K_MAX);
		update_pixel(7, 8'd200);
		update_pixel(0, 8'd17);
		update_pixel(9, 8'd60);
	endtask

	// Mostly updates of live pixels, often near their mean, with inits of new and live pixels mixed in
	task automatic test_random_traffic(int count);
		int r;
		int unsigned idx;
		logic [PIX_W-1:0] pix;
		logic [MEAN_W-1:0] m0;
		logic [VAR_W-1:0] v0;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (live_pixels.size() == 0 || r < 20) begin
				r = $urandom_range(0, 99);
				if (r < 50 && live_pixels.size() != 0)
					idx = live_pixels[$urandom_range(0, live_pixels.size() - 1)];
				else if (r < 75)
					idx = $urandom_range(0, 15);
				else
					idx = $urandom_range(0, (1 << IDX_W) - 1);
				r = $urandom_range(0, 99);
				if (r < 20)
					m0 = rand_mean();
				else
					m0 = {PIX_W'($urandom), FRAC_BITS'($urandom)};
				r = $urandom_range(0, 99);
				if (r < 10)
					v0 = '0;
				else if (r < 30)
					v0 = rand_var();
				else
					v0 = VAR_W'($urandom) << $urandom_range(0, 8);
				init_pixel(IDX_W'(idx), m0, v0);
			end else begin
				if ($urandom_range(0, 1) == 1)
					idx = live_pixels[live_pixels.size() - 1 -
						$urandom_range(0, (live_pixels.size() < 4) ?
						live_pixels.size() - 1 : 3)];
				else
					idx = live_pixels[$urandom_range(0, live_pixels.size() - 1)];
				r = $urandom_range(0, 99);
				if (r < 60) begin
					r = int'(bg_mean[idx][MEAN_W-1:FRAC_BITS]) + $urandom_range(0, 8) - 4;
					pix = (r < 0) ? 8'd0 : (r > 255) ? 8'd255 : PIX_W'(r);
				end else begin
					pix = PIX_W'($urandom);
				end
				update_pixel(IDX_W'(idx), pix);
			end
		end
	endtask

	task automatic test_random_phase(logic [ALPHA_W-1:0] a, logic [K_W-1:0] k, int count);
		drain();
		set_model(a, k);
		test_random_traffic(count);
	endtask

	// Full-rate stretch with no idling on either side
	task automatic test_back_to_back(int count);
		drain();
		no_idle = 1'b1;
		set_model(32'h4000_0000, 8'd3);
		test_random_traffic(count);
		drain();
		no_idle = 1'b0;
	endtask

	// Check each mask beat and randomize the stall
	always @(posedge clk) begin
		mask_t want;
		if (arst_n && mask_valid && !mask_stall) begin
			mask_count++;
			if (mask_due.size() == 0) begin
				$error("mask beat for index %0d with nothing outstanding", out_index);
				err_count++;
			end else begin
				want = mask_due.pop_front();
				if (out_index !== want.idx) begin
					$error("out_index: expected %0d, got %0d", want.idx, out_index);
					err_count++;
				end
				if (foreground !== want.fg) begin
					$error("foreground: expected %0b, got %0b", want.fg, foreground);
					err_count++;
				end
				if (want.fg)
					fg_count++;
			end
		end
		if (stall_left > 0) begin
			mask_stall <= 1'b1;
			stall_left--;
		end else begin
			mask_stall <= 1'b0;
			stall_left = draw_gap();
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_corners();
		test_zero_threshold();
		test_alpha_extremes();
		test_random_phase(ALPHA_RESET, K_RESET, 90);
		test_random_phase('0, '0, 100);
		test_random_phase(ALPHA_MAX, K_MAX, 100);
		test_back_to_back(100);
		repeat (4)
			test_random_phase(($urandom_range(0, 1) == 1) ? ALPHA_W'($urandom) :
				ALPHA_W'($urandom_range(0, 1 << 24)), K_W'($urandom_range(0, 8)), 110);
		drain();
		$display("%0d init and %0d update beats over %0d model settings",
			init_count, update_count, setting_count);
		$display("%0d mask beats checked, %0d of them foreground", mask_count, fg_count);
		if (err_count == 0)
			$display("gaussian_background_subtractor_test: clean");
		else
			$display("gaussian_background_subtractor_test: errors");
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("gaussian_background_subtractor_test: errors");
		$finish;
	end

endmodule

// File: sim.f
design/gbs_pkg.sv
design/gaussian_background_subtractor.sv
design/gbs_checker.sv
tb/gaussian_background_subtractor_test.sv
